@@ design/sfp_pkg.sv @@
// Package with the shared types and constants of the setpoint frame parser.
`default_nettype none
package sfp_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned SET_W  = 14;
    localparam int unsigned KIND_W = 3;
    localparam int unsigned HIGH_SHIFT = 6;

    localparam logic [BYTE_W-1:0] DATA_BIAS   = 8'h20;
    localparam logic [BYTE_W-1:0] NEWLINE     = 8'h0A;
    localparam logic [BYTE_W-1:0] CMD_HEADING = 8'h68;
    localparam logic [BYTE_W-1:0] CMD_DEPTH   = 8'h64;
    localparam logic [BYTE_W-1:0] CMD_POWER   = 8'h70;

    localparam logic [SET_W-1:0] HEADING_RESET = 14'd0;
    localparam logic [SET_W-1:0] DEPTH_RESET   = 14'd20;
    localparam logic [SET_W-1:0] POWER_RESET   = 14'd100;

    localparam logic [1:0] WINDOW_FULL = 2'd3;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE    = 3'd0,
        KIND_HEADING = 3'd1,
        KIND_DEPTH   = 3'd2,
        KIND_POWER   = 3'd3,
        KIND_UNKNOWN = 3'd4
    } t_kind;

    // Parser state that carries from one byte to the next.
    typedef struct packed {
        logic [BYTE_W-1:0] win0;
        logic [BYTE_W-1:0] win1;
        logic [BYTE_W-1:0] win2;
        logic [1:0]        held_count;
        logic [SET_W-1:0]  heading;
        logic [SET_W-1:0]  depth;
        logic [SET_W-1:0]  power;
    } t_state;

    // One result item.
    typedef struct packed {
        logic [SET_W-1:0] heading;
        logic [SET_W-1:0] depth;
        logic [SET_W-1:0] power;
        t_kind            kind;
    } t_result;

endpackage
`default_nettype wire

@@ design/setpoint_frame_parser_top.sv @@
// Top level of the setpoint frame parser: state, result register and skid stage.
// A result is registered in the output register, or in the skid register while that is held.
// Throughput: one byte per cycle while o_stall is low; the update is two bias subtracts,
// a shift, an OR and compares, then one register load.
// A skid register lets a byte transfer while a result waits to be taken.
// Reset (synchronous, active low) empties the window, sets heading 0,
// depth 20, power 100 and drops any pending result.
`default_nettype none
module setpoint_frame_parser_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [sfp_pkg::BYTE_W-1:0]   i_rx_byte,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [sfp_pkg::SET_W-1:0]         o_heading_setpoint,
    output logic [sfp_pkg::SET_W-1:0]         o_depth_setpoint,
    output logic [sfp_pkg::SET_W-1:0]         o_power_setpoint,
    output logic [sfp_pkg::KIND_W-1:0]        o_frame_kind
);
    import sfp_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;
    logic    in_xfer;
    logic    out_xfer;
    logic    out_free;

    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = r_out_valid && !i_stall;
    assign out_free = out_xfer || !r_out_valid;

    sfp_decode u_decode (
        .i_state   (r_state),
        .i_rx_byte (i_rx_byte),
        .o_state   (n_state),
        .o_result  (n_result)
    );

    // Parser state advances on every input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.win0       <= '0;
            r_state.win1       <= '0;
            r_state.win2       <= '0;
            r_state.held_count <= 2'd0;
            r_state.heading    <= HEADING_RESET;
            r_state.depth      <= DEPTH_RESET;
            r_state.power      <= POWER_RESET;
        end else if (in_xfer) begin
            r_state <= n_state;
        end
    end

    // Output register with a skid stage behind it; the skid only fills when
    // the output register is held by a stall.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_xfer;
            end
        end else if (in_xfer) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Result payload registers.
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_xfer) begin
                r_out <= n_result;
            end
        end else if (in_xfer) begin
            r_skid <= n_result;
        end
    end

    assign o_stall            = r_skid_valid;
    assign o_valid            = r_out_valid;
    assign o_heading_setpoint = r_out.heading;
    assign o_depth_setpoint   = r_out.depth;
    assign o_power_setpoint   = r_out.power;
    assign o_frame_kind       = r_out.kind;

endmodule
`default_nettype wire

@@ design/sfp_decode.sv @@
// Combinational next-state and result logic for one received byte.
`default_nettype none
module sfp_decode (
    input  wire sfp_pkg::t_state             i_state,
    input  wire logic [sfp_pkg::BYTE_W-1:0]  i_rx_byte,
    output sfp_pkg::t_state                  o_state,
    output sfp_pkg::t_result                 o_result
);
    import sfp_pkg::*;

    logic [SET_W-1:0] hi_diff;
    logic [SET_W-1:0] lo_diff;
    logic [SET_W-1:0] value;
    t_kind            kind;

    // Both data bytes lose their bias; a byte below the bias wraps negative,
    // and its sign bits take part in the OR as they stand.
    assign hi_diff = {{(SET_W-BYTE_W){1'b0}}, i_state.win1}
                   - {{(SET_W-BYTE_W){1'b0}}, DATA_BIAS};
    assign lo_diff = {{(SET_W-BYTE_W){1'b0}}, i_state.win2}
                   - {{(SET_W-BYTE_W){1'b0}}, DATA_BIAS};
    assign value   = (hi_diff << HIGH_SHIFT) | lo_diff;

    always_comb begin
        o_state = i_state;
        kind    = KIND_NONE;
        if (i_state.held_count != WINDOW_FULL) begin
            // Window still filling: append the byte whatever it is.
            unique case (i_state.held_count)
                2'd0:    o_state.win0 = i_rx_byte;
                2'd1:    o_state.win1 = i_rx_byte;
                default: o_state.win2 = i_rx_byte;
            endcase
            o_state.held_count = i_state.held_count + 2'd1;
        end else if (i_rx_byte == NEWLINE) begin
            // Complete frame: apply a known command, flag any other as unknown, and empty the window.
            unique case (i_state.win0)
                CMD_HEADING: begin
                    o_state.heading = value;
                    kind = KIND_HEADING;
                end
                CMD_DEPTH: begin
                    o_state.depth = value;
                    kind = KIND_DEPTH;
                end
                CMD_POWER: begin
                    o_state.power = value;
                    kind = KIND_POWER;
                end
                default: kind = KIND_UNKNOWN;
            endcase
            o_state.win0 = '0;
            o_state.win1 = '0;
            o_state.win2 = '0;
            o_state.held_count = 2'd0;
        end else begin
            // Resynchronize: drop the oldest byte and append the new one.
            o_state.win0 = i_state.win1;
            o_state.win1 = i_state.win2;
            o_state.win2 = i_rx_byte;
        end
    end

    assign o_result.heading = o_state.heading;
    assign o_result.depth   = o_state.depth;
    assign o_result.power   = o_state.power;
    assign o_result.kind    = kind;

endmodule
`default_nettype wire

@@ design/sfp_checker.sv @@
// Port-level checker for the setpoint frame parser and its bind statement.
`default_nettype none
module sfp_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_valid,
    input wire logic                         o_stall,
    input wire logic                         o_valid,
    input wire logic                         i_stall,
    input wire logic [sfp_pkg::KIND_W-1:0]   o_frame_kind
);
    import sfp_pkg::*;

    // No result is pending in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result pending after reset");

    // Input side only stalls while a result is held at the output.
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result held");

    // Input stall only begins after an output stall with a transfer waiting.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall && i_valid))
        else $error("input stall without a blocked output");

    // A stalled result holds its frame kind.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_frame_kind))
        else $error("stalled result changed");

    // Frame kind stays within its defined codes.
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_frame_kind == KIND_NONE || o_frame_kind == KIND_HEADING
            || o_frame_kind == KIND_DEPTH || o_frame_kind == KIND_POWER
            || o_frame_kind == KIND_UNKNOWN))
        else $error("frame kind out of range");

endmodule

bind setpoint_frame_parser_top sfp_checker u_sfp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_frame_kind (o_frame_kind)
);
`default_nettype wire

@@ tb/sv/tb_setpoint_frame_parser_top.sv @@
// Self-checking testbench for the setpoint frame parser with a predictor and random traffic.
`timescale 1ns / 1ps

module tb_setpoint_frame_parser_top;
    import sfp_pkg::*;

    // Tracks the parser window and setpoints and holds the results still to come.
    class setpoint_tracker;
        logic [BYTE_W-1:0] win [3];
        logic [1:0]        held;
        logic [SET_W-1:0]  heading;
        logic [SET_W-1:0]  depth;
        logic [SET_W-1:0]  power;
        t_result           pending_results [$];
        int unsigned       mismatches;
        int unsigned       checked;
        int unsigned       bytes_in;
        int unsigned       kind_count [5];

        function new();
            win[0] = '0;
            win[1] = '0;
            win[2] = '0;
            held = '0;
            heading = HEADING_RESET;
            depth = DEPTH_RESET;
            power = POWER_RESET;
            mismatches = 0;
            checked = 0;
            bytes_in = 0;
            foreach (kind_count[i]) kind_count[i] = 0;
        endfunction

        // Advances the window for one byte transfer and queues the result it causes.
        function void note_byte(logic [BYTE_W-1:0] rx);
            t_result     r;
            t_kind       kind;
            logic [31:0] hi_d;
            logic [31:0] lo_d;
            logic [31:0] v;
            kind = KIND_NONE;
            bytes_in++;
            if (held < WINDOW_FULL) begin
                win[held] = rx;
                held = held + 2'd1;
            end else if (rx == NEWLINE) begin
                // Data bytes below the bias go negative and are ORed in as such.
                hi_d = {24'd0, win[1]} - {24'd0, DATA_BIAS};
                lo_d = {24'd0, win[2]} - {24'd0, DATA_BIAS};
                v = (hi_d << HIGH_SHIFT) | lo_d;
                case (win[0])
                    CMD_HEADING: begin
                        heading = v[SET_W-1:0];
                        kind = KIND_HEADING;
                    end
                    CMD_DEPTH: begin
                        depth = v[SET_W-1:0];
                        kind = KIND_DEPTH;
                    end
                    CMD_POWER: begin
                        power = v[SET_W-1:0];
                        kind = KIND_POWER;
                    end
                    default: begin
                        kind = KIND_UNKNOWN;
                    end
                endcase
                win[0] = '0;
                win[1] = '0;
                win[2] = '0;
                held = '0;
            end else begin
                // Drop the oldest byte to resynchronize.
                win[0] = win[1];
                win[1] = win[2];
                win[2] = rx;
            end
            r.heading = heading;
            r.depth = depth;
            r.power = power;
            r.kind = kind;
            pending_results.push_back(r);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        // Compares one result transfer with the oldest queued expectation.
        task check_result(logic [SET_W-1:0] h, logic [SET_W-1:0] d, logic [SET_W-1:0] p,
                          logic [KIND_W-1:0] k);
            t_result e;
            if (pending_results.size() == 0) begin
                report($sformatf("result with nothing expected (kind %0d)", k));
                return;
            end
            e = pending_results.pop_front();
            checked++;
            if (e.kind <= KIND_UNKNOWN) kind_count[e.kind]++;
            if (h !== e.heading)
                report($sformatf("heading got %0d expected %0d", h, e.heading));
            if (d !== e.depth)
                report($sformatf("depth got %0d expected %0d", d, e.depth));
            if (p !== e.power)
                report($sformatf("power got %0d expected %0d", p, e.power));
            if (k !== e.kind)
                report($sformatf("frame kind got %0d expected %0d", k, e.kind));
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [BYTE_W-1:0]   i_rx_byte;
    logic                o_valid;
    logic                i_stall;
    logic [SET_W-1:0]    o_heading_setpoint;
    logic [SET_W-1:0]    o_depth_setpoint;
    logic [SET_W-1:0]    o_power_setpoint;
    logic [KIND_W-1:0]   o_frame_kind;

    setpoint_tracker     tracker;
    bit                  calm;
    int unsigned         sent;

    setpoint_frame_parser_top i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_rx_byte          (i_rx_byte),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_heading_setpoint (o_heading_setpoint),
        .o_depth_setpoint   (o_depth_setpoint),
        .o_power_setpoint   (o_power_setpoint),
        .o_frame_kind       (o_frame_kind)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Drives one byte, with an optional idle burst first, and waits for its transfer.
    task send_byte(input logic [BYTE_W-1:0] b);
        int unsigned gap;
        gap = 0;
        if (!calm && $urandom_range(3, 0) == 0) gap = $urandom_range(13, 1);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            i_rx_byte <= 8'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        tracker.note_byte(b);
        sent++;
    endtask

    task send_frame(input logic [BYTE_W-1:0] cmd, input logic [BYTE_W-1:0] b1,
                    input logic [BYTE_W-1:0] b2);
        send_byte(cmd);
        send_byte(b1);
        send_byte(b2);
        send_byte(NEWLINE);
    endtask

    // Picks a data byte, mostly from the printable range the protocol intends.
    function automatic logic [BYTE_W-1:0] data_byte();
        if ($urandom_range(1, 0) == 0) return 8'($urandom_range(8'h7F, 8'h20));
        return 8'($urandom);
    endfunction

    // Result side: random stall bursts, no new ones once the run goes calm.
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (!calm && $urandom_range(5, 0) == 0) begin
                stall_left = $urandom_range(13, 1) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Result monitor: every result transfer is checked.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0)
                tracker.check_result(o_heading_setpoint, o_depth_setpoint,
                                     o_power_setpoint, o_frame_kind);
        end
    end

    // Main sequence: reset, directed frames, random traffic, drain.
    initial begin
        int unsigned choice;
        logic [BYTE_W-1:0] cmd;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_rx_byte = '0;
        calm = 1'b0;
        sent = 0;
        tracker = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Newlines while the window fills are held as data; the fourth one ends a frame
        // whose command is a newline, which is unknown.
        repeat (4) send_byte(NEWLINE);
        // Largest data bytes, data exactly at the bias, and data below the bias.
        send_frame(CMD_HEADING, 8'hFF, 8'hFF);
        send_frame(CMD_DEPTH, DATA_BIAS, DATA_BIAS);
        send_frame(CMD_POWER, 8'h00, 8'h1F);
        // A stray leading byte is shifted out before the frame completes.
        send_byte(8'h55);
        send_frame(CMD_HEADING, 8'h7F, 8'h40);
        // Unknown command letter.
        send_frame(8'h78, 8'h41, 8'h42);

        // Mostly well-formed frames, with noise and broken frames in between.
        while (sent < 425) begin
            if (sent >= 360) calm = 1'b1;
            choice = $urandom_range(9, 0);
            case (choice)
                0: begin
                    send_byte(8'($urandom));
                end
                1: begin
                    send_byte(CMD_DEPTH);
                    send_byte(data_byte());
                end
                2: begin
                    send_frame(8'($urandom), 8'($urandom), 8'($urandom));
                end
                default: begin
                    case ($urandom_range(2, 0))
                        0: cmd = CMD_HEADING;
                        1: cmd = CMD_DEPTH;
                        default: cmd = CMD_POWER;
                    endcase
                    send_frame(cmd, data_byte(), data_byte());
                end
            endcase
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        // Drain the outstanding results, then keep watching for stray results.
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);

        $display("Run covered %0d byte transfers and %0d checked results.",
                 tracker.bytes_in, tracker.checked);
        $display("Frames: heading %0d, depth %0d, power %0d, unknown command %0d.",
                 tracker.kind_count[KIND_HEADING], tracker.kind_count[KIND_DEPTH],
                 tracker.kind_count[KIND_POWER], tracker.kind_count[KIND_UNKNOWN]);
        if (tracker.mismatches == 0) begin
            $display("** setpoint_frame_parser_top: PASSED **");
        end else begin
            $display("** setpoint_frame_parser_top: FAILED **");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5ms;
        $display("Timeout: transfers stopped before the run completed.");
        $display("** setpoint_frame_parser_top: FAILED **");
        $finish;
    end

endmodule

@@ sim.f @@
design/sfp_pkg.sv
design/sfp_decode.sv
design/setpoint_frame_parser_top.sv
design/sfp_checker.sv
tb/sv/tb_setpoint_frame_parser_top.sv
